FILE: hw/rtl/owf_pkg.sv
package owf_pkg;

  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int MAX_RADIUS = 10;
  localparam int MAX_LEVELS = 30;

  localparam int COORD_W = 7;
  localparam int ADDR_W  = 14;
  localparam int CH_W    = 8;
  localparam int BIN_W   = 5;
  localparam int COUNT_W = 9;
  localparam int SUM_W   = 17;
  localparam int PADDR_W = 4;

  localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_RADIUS_SETTING = 2'd2;
  localparam logic [1:0] REG_LEVELS_SETTING = 2'd3;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_SCAN,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [7:0] image_width;
    logic [7:0] image_height;
    logic [6:0] radius_setting;
    logic [6:0] levels_setting;
  } cfg_t;

endpackage

FILE: hw/rtl/owf_if.sv
interface owf_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [6:0] row;
  logic [6:0] col;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;
  modport source (output valid, kind, row, col, pixel_red, pixel_green, pixel_blue,
                  input ready);
  modport sink (input valid, kind, row, col, pixel_red, pixel_green, pixel_blue,
                output ready);
endinterface

interface owf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [6:0] out_row;
  logic [6:0] out_col;
  logic       bad_coordinate;
  modport source (output valid, out_red, out_green, out_blue, out_row, out_col,
                  bad_coordinate, input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_row, out_col,
                bad_coordinate, output ready);
endinterface

FILE: hw/rtl/owf_cfg.sv
module owf_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [owf_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output owf_pkg::cfg_t               cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width    <= 8'd128;
      cfg.image_height   <= 8'd128;
      cfg.radius_setting <= 7'd0;
      cfg.levels_setting <= 7'd0;
    end else if (wr_en) begin
      case (reg_idx)
        owf_pkg::REG_IMAGE_WIDTH:    cfg.image_width    <= pwdata[7:0];
        owf_pkg::REG_IMAGE_HEIGHT:   cfg.image_height   <= pwdata[7:0];
        owf_pkg::REG_RADIUS_SETTING: cfg.radius_setting <= pwdata[6:0];
        owf_pkg::REG_LEVELS_SETTING: cfg.levels_setting <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      owf_pkg::REG_IMAGE_WIDTH:    prdata = {24'd0, cfg.image_width};
      owf_pkg::REG_IMAGE_HEIGHT:   prdata = {24'd0, cfg.image_height};
      owf_pkg::REG_RADIUS_SETTING: prdata = {25'd0, cfg.radius_setting};
      owf_pkg::REG_LEVELS_SETTING: prdata = {25'd0, cfg.levels_setting};
      default:                     prdata = 32'd0;
    endcase
  end

endmodule

FILE: hw/rtl/owf_div.sv
module owf_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [owf_pkg::COUNT_W-1:0] divisor,
  input  logic [owf_pkg::SUM_W-1:0]   dividend [3],
  output logic [owf_pkg::SUM_W-1:0]   quotient [3],
  output logic                        done
);

  logic [owf_pkg::COUNT_W-1:0] rem [3];
  logic [owf_pkg::SUM_W-1:0]   num [3];
  logic [owf_pkg::COUNT_W-1:0] dvs;
  logic [4:0]                  steps;
  logic                        busy;
  logic [owf_pkg::COUNT_W:0]   trial [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      trial[i] = {rem[i], num[i][owf_pkg::SUM_W-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= 5'd0;
      end else if (busy) begin
        steps <= steps + 5'd1;
        if (steps == 5'(owf_pkg::SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Restoring division, one quotient bit per cycle in each lane.
  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      for (int i = 0; i < 3; i++) begin
        rem[i]      <= '0;
        num[i]      <= dividend[i];
        quotient[i] <= '0;
      end
    end else if (busy) begin
      for (int i = 0; i < 3; i++) begin
        num[i] <= {num[i][owf_pkg::SUM_W-2:0], 1'b0};
        if (trial[i] >= {1'b0, dvs}) begin
          rem[i]      <= owf_pkg::COUNT_W'(trial[i] - {1'b0, dvs});
          quotient[i] <= {quotient[i][owf_pkg::SUM_W-2:0], 1'b1};
        end else begin
          rem[i]      <= trial[i][owf_pkg::COUNT_W-1:0];
          quotient[i] <= {quotient[i][owf_pkg::SUM_W-2:0], 1'b0};
        end
      end
    end
  end

endmodule

FILE: hw/rtl/owf_engine.sv
module owf_engine (
  input  logic                        clk,
  input  logic                        rst,
  input  owf_pkg::cfg_t               cfg,
  owf_in_if.sink                      in_ch,
  owf_out_if.source                   out_ch,
  output logic                        div_start,
  output logic [owf_pkg::COUNT_W-1:0] div_divisor,
  output logic [owf_pkg::SUM_W-1:0]   div_dividend [3],
  input  logic [owf_pkg::SUM_W-1:0]   div_quotient [3],
  input  logic                        div_done
);

  owf_pkg::state_t state, state_next;

  logic [23:0] image_mem [owf_pkg::MAX_WIDTH * owf_pkg::MAX_HEIGHT];
  logic [23:0] rd_data;
  logic        rd_valid;

  logic [owf_pkg::COUNT_W-1:0] bin_count [owf_pkg::MAX_LEVELS];
  logic [owf_pkg::SUM_W-1:0]   bin_sum_red [owf_pkg::MAX_LEVELS];
  logic [owf_pkg::SUM_W-1:0]   bin_sum_green [owf_pkg::MAX_LEVELS];
  logic [owf_pkg::SUM_W-1:0]   bin_sum_blue [owf_pkg::MAX_LEVELS];
  logic [owf_pkg::MAX_LEVELS-1:0] bin_valid;

  logic [6:0] q_row, q_col, y, x, r1, c0, c1;
  logic [4:0] nbins;
  logic       bad;

  logic        s1_valid;
  logic [14:0] s1_prod;
  logic [7:0]  s1_red, s1_green, s1_blue;

  logic [4:0]                  scan_idx;
  logic [4:0]                  best;
  logic [owf_pkg::COUNT_W-1:0] best_n;

  logic in_acc, load_acc, query_acc, walk_last, out_load;

  // Window setup from the accepted query.
  logic [7:0]  w_clip, h_clip;
  logic [6:0]  rad_s, lev_s;
  logic [15:0] rad_prod;
  logic [3:0]  rad;
  logic [4:0]  lev;
  logic [7:0]  row_hi, col_lo, col_hi;
  logic        q_bad;

  always_comb begin
    w_clip   = (cfg.image_width  > 8'd128) ? 8'd128 : cfg.image_width;
    h_clip   = (cfg.image_height > 8'd128) ? 8'd128 : cfg.image_height;
    rad_s    = (cfg.radius_setting > 7'd100) ? 7'd100 : cfg.radius_setting;
    lev_s    = (cfg.levels_setting > 7'd100) ? 7'd100 : cfg.levels_setting;
    // 9*s/100 through a scaled reciprocal; exact for s up to 100.
    rad_prod = 16'(rad_s) * 16'd369;
    rad      = 4'(rad_prod[15:12]) + 4'd1;
    lev      = 5'(lev_s[6:2]) + 5'd5;
    row_hi   = {1'b0, in_ch.row} + {4'd0, rad};
    col_lo   = {1'b0, in_ch.col} + 8'd1;
    col_hi   = {1'b0, in_ch.col} + {4'd0, rad};
    q_bad    = ({1'b0, in_ch.row} >= h_clip) || ({1'b0, in_ch.col} >= w_clip);
  end

  assign in_ch.ready = (state == owf_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign load_acc    = in_acc && (in_ch.kind == owf_pkg::KIND_LOAD);
  assign query_acc   = in_acc && (in_ch.kind == owf_pkg::KIND_QUERY);
  assign walk_last   = (y == r1) && (x == c1);
  assign out_load    = (state == owf_pkg::ST_DONE) && (!out_ch.valid || out_ch.ready);

  // Image store: a synchronous write port and a synchronous read port, loads only in idle.
  always_ff @(posedge clk) begin
    if (load_acc) begin
      image_mem[{in_ch.row, in_ch.col}] <= {in_ch.pixel_blue, in_ch.pixel_green,
                                            in_ch.pixel_red};
    end
    rd_data <= image_mem[{y, x}];
  end

  always_ff @(posedge clk) begin
    if (query_acc) begin
      q_row <= in_ch.row;
      q_col <= in_ch.col;
      bad   <= q_bad;
      nbins <= lev;
      y     <= (in_ch.row >= 7'(rad)) ? in_ch.row - 7'(rad) : 7'd0;
      r1    <= (row_hi > h_clip - 8'd1) ? 7'(h_clip - 8'd1) : row_hi[6:0];
      x     <= (col_lo >= {4'd0, rad}) ? 7'(col_lo - {4'd0, rad}) : 7'd0;
      c0    <= (col_lo >= {4'd0, rad}) ? 7'(col_lo - {4'd0, rad}) : 7'd0;
      c1    <= (col_hi > w_clip - 8'd1) ? 7'(w_clip - 8'd1) : col_hi[6:0];
    end else if (state == owf_pkg::ST_WALK) begin
      if (x == c1) begin
        x <= c0;
        y <= y + 7'd1;
      end else begin
        x <= x + 7'd1;
      end
    end
  end

  // Pixel pipeline: store read, then bin product, then accumulate.
  logic [9:0]  px_sum;
  logic [6:0]  prod_hi;
  logic [14:0] third;
  logic [5:0]  bin_raw;
  logic [4:0]  bin;

  always_comb begin
    px_sum  = 10'(rd_data[7:0]) + 10'(rd_data[15:8]) + 10'(rd_data[23:16]);
    prod_hi = s1_prod[14:8];
    // Divide by three for values below 90.
    third   = 15'(prod_hi) * 15'd171;
    bin_raw = third[14:9];
    bin     = (bin_raw > 6'(owf_pkg::MAX_LEVELS - 1)) ? 5'(owf_pkg::MAX_LEVELS - 1)
                                                      : bin_raw[4:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      rd_valid <= (state == owf_pkg::ST_WALK);
      s1_valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_prod  <= 15'(px_sum) * 15'(nbins);
    s1_red   <= rd_data[7:0];
    s1_green <= rd_data[15:8];
    s1_blue  <= rd_data[23:16];
  end

  // Bins: a cleared bin reads as zero until its first update of the query.
  always_ff @(posedge clk) begin
    if (rst || query_acc) begin
      bin_valid <= '0;
    end else if (s1_valid) begin
      bin_valid[bin] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      if (bin_valid[bin]) begin
        bin_count[bin]     <= bin_count[bin] + 9'd1;
        bin_sum_red[bin]   <= bin_sum_red[bin] + 17'(s1_red);
        bin_sum_green[bin] <= bin_sum_green[bin] + 17'(s1_green);
        bin_sum_blue[bin]  <= bin_sum_blue[bin] + 17'(s1_blue);
      end else begin
        bin_count[bin]     <= 9'd1;
        bin_sum_red[bin]   <= 17'(s1_red);
        bin_sum_green[bin] <= 17'(s1_green);
        bin_sum_blue[bin]  <= 17'(s1_blue);
      end
    end
  end

  // Scan for the first bin with the greatest count.
  logic [owf_pkg::COUNT_W-1:0] scan_cnt;
  assign scan_cnt = bin_valid[scan_idx] ? bin_count[scan_idx] : '0;

  always_ff @(posedge clk) begin
    if (state == owf_pkg::ST_DRAIN) begin
      scan_idx <= 5'd0;
      best     <= 5'd0;
      best_n   <= '0;
    end else if (state == owf_pkg::ST_SCAN) begin
      scan_idx <= scan_idx + 5'd1;
      if (scan_cnt > best_n) begin
        best_n <= scan_cnt;
        best   <= scan_idx;
      end
    end
  end

  assign div_start       = (state == owf_pkg::ST_DIV_GO);
  assign div_divisor     = best_n;
  assign div_dividend[0] = bin_sum_red[best];
  assign div_dividend[1] = bin_sum_green[best];
  assign div_dividend[2] = bin_sum_blue[best];

  always_comb begin
    state_next = state;
    case (state)
      owf_pkg::ST_IDLE: begin
        if (query_acc) begin
          state_next = q_bad ? owf_pkg::ST_DONE : owf_pkg::ST_WALK;
        end
      end
      owf_pkg::ST_WALK:     if (walk_last) state_next = owf_pkg::ST_DRAIN;
      owf_pkg::ST_DRAIN:    if (!rd_valid && !s1_valid) state_next = owf_pkg::ST_SCAN;
      owf_pkg::ST_SCAN:     if (scan_idx == nbins - 5'd1) state_next = owf_pkg::ST_DIV_GO;
      owf_pkg::ST_DIV_GO:   state_next = owf_pkg::ST_DIV_WAIT;
      owf_pkg::ST_DIV_WAIT: if (div_done) state_next = owf_pkg::ST_DONE;
      owf_pkg::ST_DONE:     if (out_load) state_next = owf_pkg::ST_IDLE;
      default:              state_next = owf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= owf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result register; it frees the engine while the result waits.
  logic zero_out;
  assign zero_out = bad || (best_n == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.out_red        <= zero_out ? 8'd0 : div_quotient[0][7:0];
      out_ch.out_green      <= zero_out ? 8'd0 : div_quotient[1][7:0];
      out_ch.out_blue       <= zero_out ? 8'd0 : div_quotient[2][7:0];
      out_ch.out_row        <= q_row;
      out_ch.out_col        <= q_col;
      out_ch.bad_coordinate <= bad;
    end
  end

endmodule

FILE: hw/rtl/oil_paint_window_filter.sv
// Load transaction: taken while idle, no result; the next item may follow at once.
// Query: walks the clipped window (up to 420 pixels, one image store read per cycle),
// scans the bins (5..30 bins, one bin per cycle), and then runs the bit-serial
// divider. A query outside the image skips the walk, the scan and the divider.
// A finished result waits in the output register while the next item is taken.
// Synchronous reset clears control state and the registers; the image store is not cleared.
module oil_paint_window_filter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [owf_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  owf_in_if.sink                      in_ch,
  owf_out_if.source                   out_ch
);

  owf_pkg::cfg_t               cfg;
  logic                        div_start;
  logic                        div_done;
  logic [owf_pkg::COUNT_W-1:0] div_divisor;
  logic [owf_pkg::SUM_W-1:0]   div_dividend [3];
  logic [owf_pkg::SUM_W-1:0]   div_quotient [3];

  owf_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  owf_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .divisor(div_divisor),
    .dividend(div_dividend), .quotient(div_quotient), .done(div_done)
  );

  owf_engine u_engine (
    .clk(clk), .rst(rst), .cfg(cfg), .in_ch(in_ch), .out_ch(out_ch),
    .div_start(div_start), .div_divisor(div_divisor), .div_dividend(div_dividend),
    .div_quotient(div_quotient), .div_done(div_done)
  );

endmodule

FILE: hw/rtl/owf_checker.sv
module owf_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_kind,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic       bad_coordinate
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_kind == owf_pkg::KIND_QUERY |=> !in_ready)
    else $error("query did not occupy the engine");

  a_load_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_kind == owf_pkg::KIND_LOAD |=> in_ready)
    else $error("load transaction held the engine");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_coordinate |-> out_red == 8'd0 && out_green == 8'd0 &&
    out_blue == 8'd0)
    else $error("bad coordinate with nonzero color");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind oil_paint_window_filter owf_checker u_owf_checker (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .in_kind(in_ch.kind), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_red(out_ch.out_red), .out_green(out_ch.out_green), .out_blue(out_ch.out_blue),
  .bad_coordinate(out_ch.bad_coordinate)
);

FILE: tb/tb_oil_paint_window_filter.sv
module tb_oil_paint_window_filter;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [6:0] row;
    logic [6:0] col;
    logic       bad;
  } paint_result_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [owf_pkg::PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  owf_in_if  in_ch ();
  owf_out_if out_ch ();

  oil_paint_window_filter dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  // Shadow copy of the block's image store and registers.
  logic [23:0] shadow_image [owf_pkg::MAX_WIDTH*owf_pkg::MAX_HEIGHT];
  int unsigned cfg_width;
  int unsigned cfg_height;
  int unsigned cfg_radius;
  int unsigned cfg_levels;

  paint_result_t pending_pixels[$];
  int          mismatches;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  logic [23:0] palette [4];

  always #10 clk = ~clk;

  initial begin
    #100_000_000;
    $display("** oil_paint_window_filter: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  function automatic int unsigned min_u(int unsigned a, int unsigned b);
    return (a > b) ? b : a;
  endfunction

  // Oil-paint value of one output pixel under the current register settings.
  function automatic paint_result_t paint_pixel(logic [6:0] row, logic [6:0] col);
    paint_result_t res;
    int unsigned w, h, rad, nbins, px, r, g, b, bin, best, best_n;
    int          r0, r1, c0, c1;
    int unsigned cnt [owf_pkg::MAX_LEVELS];
    int unsigned sum_r [owf_pkg::MAX_LEVELS];
    int unsigned sum_g [owf_pkg::MAX_LEVELS];
    int unsigned sum_b [owf_pkg::MAX_LEVELS];
    res = '0;
    res.row = row;
    res.col = col;
    w = min_u(cfg_width, owf_pkg::MAX_WIDTH);
    h = min_u(cfg_height, owf_pkg::MAX_HEIGHT);
    if (row >= h || col >= w) begin
      res.bad = 1'b1;
      return res;
    end
    rad = min_u(min_u(cfg_radius, 100) * 9 / 100 + 1, owf_pkg::MAX_RADIUS);
    nbins = min_u(min_u(cfg_levels, 100) * 25 / 100 + 5, owf_pkg::MAX_LEVELS);
    r0 = int'(row) - int'(rad);
    r1 = int'(row) + int'(rad);
    c0 = int'(col) - int'(rad) + 1;
    c1 = int'(col) + int'(rad);
    if (r0 < 0) r0 = 0;
    if (r1 > int'(h) - 1) r1 = int'(h) - 1;
    if (c0 < 0) c0 = 0;
    if (c1 > int'(w) - 1) c1 = int'(w) - 1;
    for (int i = 0; i < owf_pkg::MAX_LEVELS; i++) begin
      cnt[i] = 0;
      sum_r[i] = 0;
      sum_g[i] = 0;
      sum_b[i] = 0;
    end
    for (int y = r0; y <= r1; y++) begin
      for (int x = c0; x <= c1; x++) begin
        px = 32'(shadow_image[y * owf_pkg::MAX_WIDTH + x]);
        r = px & 32'hFF;
        g = (px >> 8) & 32'hFF;
        b = (px >> 16) & 32'hFF;
        bin = min_u((r + g + b) * nbins / 768, owf_pkg::MAX_LEVELS - 1);
        cnt[bin]++;
        sum_r[bin] += r;
        sum_g[bin] += g;
        sum_b[bin] += b;
      end
    end
    best = 0;
    best_n = 0;
    for (int i = 0; i < int'(nbins); i++) begin
      if (cnt[i] > best_n) begin
        best_n = cnt[i];
        best = i;
      end
    end
    if (best_n != 0) begin
      res.red = 8'(sum_r[best] / best_n);
      res.green = 8'(sum_g[best] / best_n);
      res.blue = 8'(sum_b[best] / best_n);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    paint_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result at row %0d col %0d", out_ch.out_row, out_ch.out_col);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_ch.out_red !== want.red) begin
          $error("out_red: expected %0d, got %0d", want.red, out_ch.out_red);
          mismatches++;
        end
        if (out_ch.out_green !== want.green) begin
          $error("out_green: expected %0d, got %0d", want.green, out_ch.out_green);
          mismatches++;
        end
        if (out_ch.out_blue !== want.blue) begin
          $error("out_blue: expected %0d, got %0d", want.blue, out_ch.out_blue);
          mismatches++;
        end
        if (out_ch.out_row !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, out_ch.out_row);
          mismatches++;
        end
        if (out_ch.out_col !== want.col) begin
          $error("out_col: expected %0d, got %0d", want.col, out_ch.out_col);
          mismatches++;
        end
        if (out_ch.bad_coordinate !== want.bad) begin
          $error("bad_coordinate: expected %0d, got %0d", want.bad, out_ch.bad_coordinate);
          mismatches++;
        end
      end
    end
  end

  task automatic send_item(logic kind, logic [6:0] row, logic [6:0] col, logic [23:0] px);
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.row <= row;
    in_ch.col <= col;
    in_ch.pixel_red <= px[7:0];
    in_ch.pixel_green <= px[15:8];
    in_ch.pixel_blue <= px[23:16];
    do @(posedge clk); while (!in_ch.ready);
    if (kind == owf_pkg::KIND_LOAD) begin
      shadow_image[row * owf_pkg::MAX_WIDTH + col] = px;
    end else begin
      pending_pixels.push_back(paint_pixel(row, col));
    end
    // Leaving valid high lets the next transaction follow back to back.
    if ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    int guard;
    in_ch.valid <= 1'b0;
    guard = 0;
    while (pending_pixels.size() != 0 && guard < 2_000_000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (index)
      owf_pkg::REG_IMAGE_WIDTH:    cfg_width = value & 32'hFF;
      owf_pkg::REG_IMAGE_HEIGHT:   cfg_height = value & 32'hFF;
      owf_pkg::REG_RADIUS_SETTING: cfg_radius = value & 32'h7F;
      owf_pkg::REG_LEVELS_SETTING: cfg_levels = value & 32'h7F;
      default: ;
    endcase
  endtask

  task automatic configure(int unsigned w, int unsigned h, int unsigned rs, int unsigned ls);
    wait_idle();
    write_reg(owf_pkg::REG_IMAGE_WIDTH, w);
    write_reg(owf_pkg::REG_IMAGE_HEIGHT, h);
    write_reg(owf_pkg::REG_RADIUS_SETTING, rs);
    write_reg(owf_pkg::REG_LEVELS_SETTING, ls);
  endtask

  function automatic logic [23:0] random_pixel();
    if ($urandom_range(1)) return palette[$urandom_range(3)];
    return 24'($urandom);
  endfunction

  // Every pixel a query may read lies inside the configured image, so the
  // whole image is written before any query of a phase.
  task automatic load_image();
    for (int y = 0; y < int'(min_u(cfg_height, owf_pkg::MAX_HEIGHT)); y++) begin
      for (int x = 0; x < int'(min_u(cfg_width, owf_pkg::MAX_WIDTH)); x++) begin
        send_item(owf_pkg::KIND_LOAD, 7'(y), 7'(x), random_pixel());
      end
    end
  endtask

  task automatic test_corners();
    configure(3, 3, 0, 0);
    send_item(owf_pkg::KIND_LOAD, 7'd0, 7'd0, 24'h000000);
    send_item(owf_pkg::KIND_LOAD, 7'd0, 7'd1, 24'hFFFFFF);
    send_item(owf_pkg::KIND_LOAD, 7'd0, 7'd2, 24'hFFFFFF);
    send_item(owf_pkg::KIND_LOAD, 7'd1, 7'd0, 24'h0000FF);
    send_item(owf_pkg::KIND_LOAD, 7'd1, 7'd1, 24'h00FF00);
    send_item(owf_pkg::KIND_LOAD, 7'd1, 7'd2, 24'hFF0000);
    send_item(owf_pkg::KIND_LOAD, 7'd2, 7'd0, 24'h000000);
    send_item(owf_pkg::KIND_LOAD, 7'd2, 7'd1, 24'h808080);
    send_item(owf_pkg::KIND_LOAD, 7'd2, 7'd2, 24'hFFFFFF);
    send_item(owf_pkg::KIND_QUERY, 7'd0, 7'd0, 24'hFFFFFF);
    send_item(owf_pkg::KIND_QUERY, 7'd2, 7'd2, 24'h000000);
    send_item(owf_pkg::KIND_QUERY, 7'd1, 7'd1, 24'h000000);
    send_item(owf_pkg::KIND_QUERY, 7'd3, 7'd0, 24'h000000);
    send_item(owf_pkg::KIND_QUERY, 7'd0, 7'd3, 24'h000000);
    send_item(owf_pkg::KIND_QUERY, 7'd127, 7'd127, 24'h000000);
    // A load outside the configured size still lands in the store.
    send_item(owf_pkg::KIND_LOAD, 7'd127, 7'd127, 24'hABCDEF);
    configure(3, 3, 100, 100);
    send_item(owf_pkg::KIND_QUERY, 7'd1, 7'd1, 24'h000000);
    send_item(owf_pkg::KIND_QUERY, 7'd2, 7'd0, 24'h000000);
    configure(3, 3, 127, 127);
    send_item(owf_pkg::KIND_QUERY, 7'd0, 7'd2, 24'h000000);
    configure(0, 3, 50, 50);
    send_item(owf_pkg::KIND_QUERY, 7'd0, 7'd0, 24'h000000);
    configure(3, 0, 50, 50);
    send_item(owf_pkg::KIND_QUERY, 7'd1, 7'd1, 24'h000000);
  endtask

  task automatic test_large_windows();
    // Width above the store saturates to the full store width.
    configure(255, 1, 100, 100);
    load_image();
    send_item(owf_pkg::KIND_QUERY, 7'd0, 7'd127, 24'd0);
    send_item(owf_pkg::KIND_QUERY, 7'd0, 7'd0, 24'd0);
    send_item(owf_pkg::KIND_QUERY, 7'd0, 7'd64, 24'd0);
    configure(1, 128, 100, 0);
    load_image();
    send_item(owf_pkg::KIND_QUERY, 7'd127, 7'd0, 24'd0);
    send_item(owf_pkg::KIND_QUERY, 7'd0, 7'd0, 24'd0);
    // Full 21 by 20 window.
    configure(21, 21, 100, 100);
    load_image();
    send_item(owf_pkg::KIND_QUERY, 7'd10, 7'd10, 24'd0);
    send_item(owf_pkg::KIND_QUERY, 7'd10, 7'd9, 24'd0);
    configure(21, 21, 55, 77);
    send_item(owf_pkg::KIND_QUERY, 7'd12, 7'd10, 24'd0);
  endtask

  task automatic test_random_traffic();
    int unsigned idle_table [4] = '{0, 61, 0, 26};
    int unsigned stall_table [4] = '{0, 0, 61, 26};
    int unsigned w, h;
    for (int p = 0; p < 4; p++) begin
      sender_idle_pct = idle_table[p];
      receiver_stall_pct = stall_table[p];
      for (int s = 0; s < 2; s++) begin
        for (int i = 0; i < 4; i++) palette[i] = 24'($urandom);
        w = $urandom_range(1) ? $urandom_range(8, 1) : $urandom_range(14, 1);
        h = $urandom_range(1) ? $urandom_range(8, 1) : $urandom_range(14, 1);
        configure(w, h, $urandom_range(127), $urandom_range(127));
        load_image();
        for (int n = 0; n < 20; n++) begin
          if ($urandom_range(99) < 70) begin
            if ($urandom_range(9) == 0) begin
              send_item(owf_pkg::KIND_QUERY, 7'($urandom_range(127)),
                        7'($urandom_range(127)), 24'($urandom));
            end else begin
              send_item(owf_pkg::KIND_QUERY, 7'($urandom_range(h - 1)),
                        7'($urandom_range(w - 1)), 24'($urandom));
            end
          end else begin
            send_item(owf_pkg::KIND_LOAD, 7'($urandom_range(127)),
                      7'($urandom_range(127)), random_pixel());
          end
        end
      end
    end
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
  endtask

  initial begin
    clk = 1'b0;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.kind <= owf_pkg::KIND_LOAD;
    in_ch.row <= '0;
    in_ch.col <= '0;
    in_ch.pixel_red <= '0;
    in_ch.pixel_green <= '0;
    in_ch.pixel_blue <= '0;
    mismatches = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    cfg_width = 128;
    cfg_height = 128;
    cfg_radius = 0;
    cfg_levels = 0;
    for (int i = 0; i < 4; i++) palette[i] = 24'($urandom);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corners();
    test_large_windows();
    test_random_traffic();

    wait_idle();
    repeat (600) @(posedge clk);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("** oil_paint_window_filter: PASSED **");
    end else begin
      if (pending_pixels.size() != 0) begin
        $error("%0d expected results never arrived", pending_pixels.size());
      end
      $display("** oil_paint_window_filter: FAILED **");
    end
    $finish;
  end

endmodule
